>>> src/dq_pkg.sv
// dq_pkg: shared types and codes for the double-ended queue core
// no dependencies; used by dq_ctrl, dq_dpath and double_ended_queue_core
package dq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } dq_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } dq_state_t;

  // controller to datapath
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       list_clear;
    logic       list_read;
    logic       emit;
    logic       from_mem;
    dq_status_t status;
    logic       last;
  } dq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
  } dq_stat_t;

endpackage

>>> src/dq_ctrl.sv
// dq_ctrl: command decoder and list sequencer for the queue core
// depends on dq_pkg; drives dq_dpath through dq_pkg::dq_ctl_t
module dq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dq_pkg::CMD_W-1:0]    command,
  input  dq_pkg::dq_stat_t            stat,
  output dq_pkg::dq_ctl_t             ctl,
  output logic                        busy
);

  dq_pkg::dq_state_t state;
  dq_pkg::dq_state_t state_next;
  logic              accept;

  assign accept = start && (state == dq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dq_pkg::S_IDLE: begin
        if (accept && (dq_pkg::dq_cmd_t'(command) == dq_pkg::CMD_LIST) && !stat.empty) begin
          state_next = dq_pkg::S_LIST;
        end
      end
      dq_pkg::S_LIST: begin
        if (stat.list_last) begin
          state_next = dq_pkg::S_IDLE;
        end
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.status = dq_pkg::ST_OK;
    busy       = 1'b0;
    case (state)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          case (dq_pkg::dq_cmd_t'(command))
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              if (stat.full) begin
                ctl.status = dq_pkg::ST_FULL;
              end else begin
                ctl.push_front = (dq_pkg::dq_cmd_t'(command) == dq_pkg::CMD_PUSH_FRONT);
                ctl.push_back  = (dq_pkg::dq_cmd_t'(command) == dq_pkg::CMD_PUSH_BACK);
              end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
              ctl.emit = 1'b1;
              ctl.last = 1'b1;
              if (stat.empty) begin
                ctl.status = dq_pkg::ST_EMPTY;
              end else begin
                ctl.from_mem  = 1'b1;
                ctl.pop_front = (dq_pkg::dq_cmd_t'(command) == dq_pkg::CMD_POP_FRONT);
                ctl.pop_back  = (dq_pkg::dq_cmd_t'(command) == dq_pkg::CMD_POP_BACK);
              end
            end
            dq_pkg::CMD_LIST: begin
              if (stat.empty) begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                ctl.status = dq_pkg::ST_EMPTY;
              end else begin
                ctl.list_clear = 1'b1;
              end
            end
            default: ctl = ctl; // unused codes: no result
          endcase
        end
      end
      dq_pkg::S_LIST: begin
        busy          = 1'b1;
        ctl.list_read = 1'b1;
        ctl.emit      = 1'b1;
        ctl.from_mem  = 1'b1;
        ctl.last      = stat.list_last;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

>>> src/dq_dpath.sv
// dq_dpath: ring storage, head/count pointers, list index and result registers
// depends on dq_pkg; sequenced by dq_ctrl
module dq_dpath #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dq_pkg::dq_ctl_t                   ctl,
  input  logic signed [dq_pkg::WORD_W-1:0]  value,
  output dq_pkg::dq_stat_t                  stat,
  output logic                              strobe,
  output logic [dq_pkg::STATUS_W-1:0]       status,
  output logic signed [dq_pkg::WORD_W-1:0]  item,
  output logic                              last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  logic [dq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [dq_pkg::WORD_W-1:0] rdata;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] idx;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] head_dec;
  logic          we;
  logic          re;

  logic                 from_mem;
  dq_pkg::dq_status_t   status_q;

  // fold an index below twice the depth back into the ring
  function automatic logic [AW-1:0] ring(input logic [SW-1:0] a);
    ring = (a >= SW'(DEPTH)) ? AW'(a - SW'(DEPTH)) : AW'(a);
  endfunction

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.list_last = ((SW'(idx) + SW'(1)) == SW'(count));

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  always_comb begin
    waddr = ctl.push_front ? head_dec : ring({1'b0, head} + SW'(count));
    if (ctl.pop_front) begin
      raddr = head;
    end else if (ctl.pop_back) begin
      raddr = ring({1'b0, head} + SW'(count) - SW'(1));
    end else begin
      raddr = ring({1'b0, head} + SW'(idx));
    end
  end

  assign we = ctl.push_front || ctl.push_back;
  assign re = ctl.pop_front || ctl.pop_back || ctl.list_read;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctl.push_front) begin
      head_next = head_dec;
    end
    if (ctl.pop_front) begin
      head_next = ring({1'b0, head} + SW'(1));
    end
    if (we) begin
      count_next = count + CW'(1);
    end else if (ctl.pop_front || ctl.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      head   <= head_next;
      count  <= count_next;
      strobe <= ctl.emit;
    end
  end

  // list walk index and result fields
  always_ff @(posedge clk) begin
    if (ctl.list_clear) begin
      idx <= '0;
    end else if (ctl.list_read) begin
      idx <= idx + AW'(1);
    end
    if (ctl.emit) begin
      status_q <= ctl.status;
      last     <= ctl.last;
      from_mem <= ctl.from_mem;
    end
  end

  assign status = status_q;
  assign item   = from_mem ? rdata : '0;

endmodule

>>> src/double_ended_queue_core.sv
// double_ended_queue_core: top level of the bounded double-ended queue
// depends on dq_pkg, dq_ctrl and dq_dpath
//
//   channel   signals                   direction  flow
//   command   start, command, value     in         taken when start & !busy
//   result    strobe, status, item, last out       each beat shown for one cycle, no stall
//
// push and pop return their result beat in the next cycle
// list on an empty queue answers with one empty beat; else it clears the index, then does one ring read per entry
// the single-port read of the ring sets the list walk at one beat per cycle
// busy is high only during the list walk; rst clears head, count and the fsm
// results cannot be held off, every beat is on the ports for one cycle
module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dq_pkg::CMD_W-1:0]          command,
  input  logic signed [dq_pkg::WORD_W-1:0]  value,
  output logic                              busy,
  output logic                              strobe,
  output logic [dq_pkg::STATUS_W-1:0]       status,
  output logic signed [dq_pkg::WORD_W-1:0]  item,
  output logic                              last
);

  dq_pkg::dq_ctl_t  ctl;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .value  (value),
    .stat   (stat),
    .strobe (strobe),
    .status (status),
    .item   (item),
    .last   (last)
  );

  // every error report closes its command
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != 2'(dq_pkg::ST_OK)) |-> last)
    else $error("error beat without last");

  // push and pop always answer in the next cycle
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command < 3'(dq_pkg::CMD_LIST)) |=> strobe && last)
    else $error("push or pop without result beat");

  // a list walk only starts from an accepted list command
  a_list_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && ($past(command) == 3'(dq_pkg::CMD_LIST)))
    else $error("list walk without list command");

  // each cycle of the walk after the first emits a beat
  a_walk_beats: assert property (@(posedge clk) disable iff (rst)
    busy && $past(busy) |-> strobe)
    else $error("gap in list beats");

endmodule

>>> tb/tb_double_ended_queue_core.sv
// tb_double_ended_queue_core: self-checking bench for the double-ended queue core
// depends on dq_pkg and double_ended_queue_core; a queue predictor in a small class
// checks every result beat against directed and random command streams
module tb_double_ended_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned DEPTH         = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS  = 312;
  localparam int unsigned QUIET_TAIL    = 60;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = DEPTH + 4;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [CMD_W-1:0] FIRST_UNUSED_CMD = CMD_W'(CMD_LIST + 1);
  localparam logic [CMD_W-1:0] LAST_UNUSED_CMD  = {CMD_W{1'b1}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct {
    dq_status_t                 status;
    logic signed [WORD_W-1:0]   word;
    logic                       fin;
  } dq_beat_t;

  class dq_scoreboard;
    logic signed [WORD_W-1:0] ring_mem [DEPTH];
    int unsigned head_idx;
    int unsigned fill;
    dq_beat_t    awaited[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned commands;
    int unsigned ignored;
    int unsigned list_walks;
    int unsigned full_hits;
    int unsigned empty_hits;

    function new();
      head_idx = 0;
      fill     = 0;
    endfunction

    function void push_beat(dq_status_t st, logic signed [WORD_W-1:0] w, logic fin);
      dq_beat_t b;
      b.status = st;
      b.word   = w;
      b.fin    = fin;
      awaited.push_back(b);
    endfunction

    // predict the beats caused by one accepted command
    function void note(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] val);
      int unsigned slot;
      commands++;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            full_hits++;
            push_beat(ST_FULL, '0, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
              slot = head_idx;
            end else begin
              slot = (head_idx + fill) % DEPTH;
            end
            ring_mem[slot] = val;
            fill++;
            push_beat(ST_OK, '0, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (fill == 0) begin
            empty_hits++;
            push_beat(ST_EMPTY, '0, 1'b1);
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              slot = head_idx;
              head_idx = (head_idx + 1) % DEPTH;
            end else begin
              slot = (head_idx + fill - 1) % DEPTH;
            end
            fill--;
            push_beat(ST_OK, ring_mem[slot], 1'b1);
          end
        end
        CMD_LIST: begin
          list_walks++;
          if (fill == 0) begin
            empty_hits++;
            push_beat(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              push_beat(ST_OK, ring_mem[(head_idx + i) % DEPTH], i + 1 == fill);
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void check(logic [STATUS_W-1:0] st, logic signed [WORD_W-1:0] w, logic fin);
      dq_beat_t e;
      beats_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected beat: status %0d item %0d last %0b", st, w, fin);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || w !== e.word || fin !== e.fin) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("beat %0d mismatch: expected status %0d item %0d last %0b, got %0d %0d %0b",
                   beats_checked, e.status, e.word, e.fin, st, w, fin);
      end
    endfunction
  endclass

  logic                     clk     = 1'b0;
  logic                     rst     = 1'b1;
  logic                     start   = 1'b0;
  logic [CMD_W-1:0]         command = '0;
  logic signed [WORD_W-1:0] value   = '0;
  logic                     busy;
  logic                     strobe;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] item;
  logic                     last;

  dq_scoreboard sb = new();
  int unsigned  cycles = 0;

  double_ended_queue_core #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .command(command), .value(value),
    .busy(busy), .strobe(strobe), .status(status), .item(item), .last(last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_double_ended_queue_core failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe)
      sb.check(status, item, last);
  end

  // hold the command until it is taken, then optionally idle
  task automatic send(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] val,
                      input int unsigned gap);
    start   <= 1'b1;
    command <= cmd;
    value   <= val;
    do @(posedge clk); while (busy);
    sb.note(cmd, val);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_cmd(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return CMD_W'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
    if (r < 14)
      return CMD_LIST;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  initial begin
    int unsigned      push_bias [5];
    int unsigned      n;
    int unsigned      gap;
    logic [CMD_W-1:0] cmd;

    push_bias = '{80, 50, 20, 65, 30};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty queue, extreme words, ignored codes, draining to empty
    send(CMD_LIST, '0, 0);
    send(CMD_POP_FRONT, '0, 0);
    send(CMD_POP_BACK, '0, 1);
    send(CMD_PUSH_FRONT, WORD_MAX, 0);
    send(CMD_PUSH_BACK, WORD_MIN, 0);
    send(CMD_PUSH_FRONT, '0, 2);
    send(CMD_PUSH_BACK, '1, 0);
    send(CMD_LIST, '0, 0);
    for (int unsigned c = FIRST_UNUSED_CMD; c <= LAST_UNUSED_CMD; c++)
      send(CMD_W'(c), '1, 0);
    send(CMD_POP_BACK, '0, 0);
    send(CMD_POP_FRONT, '0, 3);
    send(CMD_LIST, '0, 0);
    send(CMD_POP_FRONT, '0, 0);
    send(CMD_POP_BACK, '0, 0);
    send(CMD_POP_FRONT, '0, 0);
    send(CMD_LIST, '0, 0);

    // phases lean toward filling or draining so full and empty come up often
    n = 0;
    while (n < RANDOM_ITEMS) begin
      cmd = rand_cmd(push_bias[(n / 40) % 5]);
      gap = 0;
      if (n + QUIET_TAIL < RANDOM_ITEMS && (n / 25) % 3 != 2 && $urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 5);
      send(cmd, rand_word(), gap);
      if (cmd <= CMD_LIST)
        n++;
    end
    start <= 1'b0;

    while (sb.awaited.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands sent (%0d ignored codes), %0d beats checked",
             sb.commands, sb.ignored, sb.beats_checked);
    $display("%0d list walks, queue full %0d times, empty %0d times",
             sb.list_walks, sb.full_hits, sb.empty_hits);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("tb_double_ended_queue_core passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_double_ended_queue_core failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_dpath.sv
src/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
